// ----- sv/ppmd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared constants and types of the PPM frame decoder with drive mapping.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  localparam int unsigned TIMER_PERIOD = 40000;
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned NUM_DRIVES   = 6;
  localparam int unsigned WIDTH_RESET  = 1500;
  localparam int unsigned PCT_SCALE    = 100;
  localparam int unsigned MAG_SAT      = 255;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned PW_W    = 15;
  localparam int unsigned DZ_W    = 10;
  localparam int unsigned CH_W    = $clog2(NUM_CHANNELS);
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned MAG_W   = 8;
  localparam int unsigned NUM_W   = 22;
  localparam int unsigned REM_W   = NUM_W + 1;
  localparam int unsigned QCNT_W  = $clog2(MAG_W);
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [2:0] REG_PULSE_CENTER   = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX      = 3'd1;
  localparam logic [2:0] REG_PULSE_MIN      = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE      = 3'd3;
  localparam logic [2:0] REG_GLITCH_LIMIT   = 3'd4;
  localparam logic [2:0] REG_SYNC_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_LIMIT_CHANNEL  = 3'd6;

  typedef struct packed {
    logic [PW_W-1:0] pulse_center;
    logic [PW_W-1:0] pulse_max;
    logic [PW_W-1:0] pulse_min;
    logic [DZ_W-1:0] dead_zone;
    logic [PW_W-1:0] glitch_limit;
    logic [PW_W-1:0] sync_threshold;
    logic [2:0]      limit_channel;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic filter;
    logic map;
    logic scale;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic sync;
    logic full;
    logic drive;
    logic div_last;
  } dp_status_t;

  typedef struct packed {
    logic            updated;
    logic [2:0]      channel;
    logic [PW_W-1:0] pulse_width;
    logic            glitch_rejected;
    logic            sync_seen;
    logic            frame_done;
    logic            drive_valid;
    logic            direction;
    logic [MAG_W-1:0] magnitude;
  } result_t;

endpackage

// ----- sv/ppmd_if.sv -----
// ----------------------------------------------------------------------------
// ppmd_in_if / ppmd_out_if
// Valid/ready channels carrying edge items in and decoded results out.
// ----------------------------------------------------------------------------
interface ppmd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] edge_time;
  logic        upper_limit_n;
  logic        lower_limit_n;

  modport source (output valid, output edge_time, output upper_limit_n,
                  output lower_limit_n, input ready);
  modport sink   (input valid, input edge_time, input upper_limit_n,
                  input lower_limit_n, output ready);
endinterface

interface ppmd_out_if;
  logic        valid;
  logic        ready;
  logic        updated;
  logic [2:0]  channel;
  logic [14:0] pulse_width;
  logic        glitch_rejected;
  logic        sync_seen;
  logic        frame_done;
  logic        drive_valid;
  logic        direction;
  logic [7:0]  magnitude;

  modport source (output valid, output updated, output channel, output pulse_width,
                  output glitch_rejected, output sync_seen, output frame_done,
                  output drive_valid, output direction, output magnitude,
                  input ready);
  modport sink   (input valid, input updated, input channel, input pulse_width,
                  input glitch_rejected, input sync_seen, input frame_done,
                  input drive_valid, input direction, input magnitude,
                  output ready);
endinterface

// ----- sv/ppmd_cfg.sv -----
// ----------------------------------------------------------------------------
// ppmd_cfg
// APB register file holding calibration and limit channel selection.
// ----------------------------------------------------------------------------
module ppmd_cfg
  import ppmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_center   <= PW_W'(WIDTH_RESET);
      cfg_q.pulse_max      <= PW_W'(2000);
      cfg_q.pulse_min      <= PW_W'(1000);
      cfg_q.dead_zone      <= DZ_W'(50);
      cfg_q.glitch_limit   <= PW_W'(300);
      cfg_q.sync_threshold <= PW_W'(2100);
      cfg_q.limit_channel  <= 3'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE_CENTER:   cfg_q.pulse_center   <= pwdata[PW_W-1:0];
        REG_PULSE_MAX:      cfg_q.pulse_max      <= pwdata[PW_W-1:0];
        REG_PULSE_MIN:      cfg_q.pulse_min      <= pwdata[PW_W-1:0];
        REG_DEAD_ZONE:      cfg_q.dead_zone      <= pwdata[DZ_W-1:0];
        REG_GLITCH_LIMIT:   cfg_q.glitch_limit   <= pwdata[PW_W-1:0];
        REG_SYNC_THRESHOLD: cfg_q.sync_threshold <= pwdata[PW_W-1:0];
        REG_LIMIT_CHANNEL:  cfg_q.limit_channel  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULSE_CENTER:   prdata = DATA_W'(cfg_q.pulse_center);
      REG_PULSE_MAX:      prdata = DATA_W'(cfg_q.pulse_max);
      REG_PULSE_MIN:      prdata = DATA_W'(cfg_q.pulse_min);
      REG_DEAD_ZONE:      prdata = DATA_W'(cfg_q.dead_zone);
      REG_GLITCH_LIMIT:   prdata = DATA_W'(cfg_q.glitch_limit);
      REG_SYNC_THRESHOLD: prdata = DATA_W'(cfg_q.sync_threshold);
      REG_LIMIT_CHANNEL:  prdata = DATA_W'(cfg_q.limit_channel);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/ppmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppmd_ctrl
// Sequencer stepping one edge through filter, mapping and serial division.
// ----------------------------------------------------------------------------
module ppmd_ctrl
  import ppmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILT  = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_FILT;
        end
      end
      S_FILT: begin
        cmd_o.filter = 1'b1;
        if (status_i.sync || status_i.full || !status_i.drive) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("result register overwritten while held");

  a_accept_to_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_FILT))
    else $error("accepted transfer not followed by filter step");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result loaded without valid");

endmodule

// ----- sv/ppmd_dp.sv -----
// ----------------------------------------------------------------------------
// ppmd_dp
// Interval, glitch filter, width store, drive mapping and restoring divider.
// ----------------------------------------------------------------------------
module ppmd_dp
  import ppmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [TIME_W-1:0] edge_time_i,
  input  logic              upper_limit_n_i,
  input  logic              lower_limit_n_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output result_t           result_o
);

  logic [TIME_W-1:0] last_edge_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PW_W-1:0]   widths_q [NUM_CHANNELS];

  logic [PW_W-1:0]   interval_q;
  logic              upper_hit_q, lower_hit_q;

  logic              sync_q, upd_q, rej_q, done_q, drv_q, dir_q;
  logic [2:0]        ch_q;
  logic [PW_W-1:0]   w_q;

  logic [PW_W-1:0]   dev_q, span_q;
  logic              span_bad_q, dz_q, sat_q;
  logic [REM_W-1:0]  rem_q;
  logic [MAG_W-1:0]  quo_q;
  logic [QCNT_W-1:0] cnt_q;

  result_t           out_q;

  logic [TIME_W:0]   wrap_sum;
  logic [TIME_W-1:0] diff_time;
  logic [PW_W-1:0]   interval;
  logic [PW_W-1:0]   old_w, jump, new_w;
  logic              reject;
  logic [IDX_W-1:0]  idx_next;
  logic              above;
  logic [PW_W-1:0]   dev;
  logic [PW_W:0]     span;
  logic [NUM_W-1:0]  num;
  logic [REM_W-1:0]  dshift;
  logic              fits;
  logic [MAG_W-1:0]  mag_raw, mag_fin;
  logic              boom_block;

  assign wrap_sum  = {1'b0, edge_time_i} + (TIME_W+1)'(TIMER_PERIOD) - {1'b0, last_edge_q};
  assign diff_time = edge_time_i - last_edge_q;
  assign interval  = (edge_time_i < last_edge_q) ?
                     (wrap_sum[TIME_W] ? '1 : wrap_sum[PW_W:1]) : diff_time[PW_W:1];

  assign status_o.sync     = (interval_q >= cfg_i.sync_threshold);
  assign status_o.full     = (idx_q >= IDX_W'(NUM_CHANNELS));
  assign status_o.drive    = (idx_q < IDX_W'(NUM_DRIVES));
  assign status_o.div_last = (cnt_q == '0);

  assign old_w    = widths_q[idx_q[CH_W-1:0]];
  assign jump     = (old_w > interval_q) ? old_w - interval_q : interval_q - old_w;
  assign reject   = (jump > cfg_i.glitch_limit);
  assign new_w    = reject ? old_w : interval_q;
  assign idx_next = idx_q + IDX_W'(1);

  assign above = (w_q > cfg_i.pulse_center);
  assign dev   = above ? w_q - cfg_i.pulse_center : cfg_i.pulse_center - w_q;
  assign span  = above ? {1'b0, cfg_i.pulse_max} - {1'b0, cfg_i.pulse_center}
                       : {1'b0, cfg_i.pulse_center} - {1'b0, cfg_i.pulse_min};

  assign num    = NUM_W'(dev_q) * NUM_W'(PCT_SCALE);
  assign dshift = REM_W'(span_q) << cnt_q;
  assign fits   = (rem_q >= dshift);

  assign mag_raw    = dz_q ? '0 : ((span_bad_q || sat_q) ? MAG_W'(MAG_SAT) : quo_q);
  assign boom_block = (ch_q == cfg_i.limit_channel) &&
                      ((upper_hit_q && dir_q) || (lower_hit_q && !dir_q));
  assign mag_fin    = (drv_q && !boom_block) ? mag_raw : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      idx_q       <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        widths_q[i] <= PW_W'(WIDTH_RESET);
      end
    end else begin
      if (cmd_i.capture) begin
        last_edge_q <= edge_time_i;
      end
      if (cmd_i.filter) begin
        if (status_o.sync) begin
          idx_q <= '0;
        end else if (!status_o.full) begin
          widths_q[idx_q[CH_W-1:0]] <= new_w;
          idx_q                     <= idx_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      interval_q  <= interval;
      upper_hit_q <= ~upper_limit_n_i;
      lower_hit_q <= ~lower_limit_n_i;
    end
    if (cmd_i.filter) begin
      sync_q <= status_o.sync;
      upd_q  <= 1'b0;
      ch_q   <= '0;
      w_q    <= '0;
      rej_q  <= 1'b0;
      done_q <= 1'b0;
      drv_q  <= 1'b0;
      dir_q  <= 1'b0;
      if (!status_o.sync && !status_o.full) begin
        upd_q  <= 1'b1;
        ch_q   <= idx_q[2:0];
        w_q    <= new_w;
        rej_q  <= reject;
        done_q <= (idx_next == IDX_W'(NUM_CHANNELS));
        drv_q  <= status_o.drive;
      end
    end
    if (cmd_i.map) begin
      dev_q      <= dev;
      span_q     <= span[PW_W-1:0];
      span_bad_q <= span[PW_W] || (span == '0);
      dz_q       <= (dev <= PW_W'(cfg_i.dead_zone));
      dir_q      <= above || (dev <= PW_W'(cfg_i.dead_zone));
    end
    if (cmd_i.scale) begin
      rem_q <= REM_W'(num);
      sat_q <= ({1'b0, num} >= {span_q, 8'h00});
      quo_q <= '0;
      cnt_q <= QCNT_W'(MAG_W - 1);
    end
    if (cmd_i.div_step) begin
      if (fits) begin
        rem_q        <= rem_q - dshift;
        quo_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - QCNT_W'(1);
    end
    if (cmd_i.load_out) begin
      out_q.updated         <= upd_q;
      out_q.channel         <= ch_q;
      out_q.pulse_width     <= w_q;
      out_q.glitch_rejected <= rej_q;
      out_q.sync_seen       <= sync_q;
      out_q.frame_done      <= done_q;
      out_q.drive_valid     <= drv_q;
      out_q.direction       <= drv_q & dir_q;
      out_q.magnitude       <= mag_fin;
    end
  end

  assign result_o = out_q;

endmodule

// ----- sv/ppm_frame_decoder_with_drive_mapping.sv -----
// ----------------------------------------------------------------------------
// ppm_frame_decoder_with_drive_mapping
// Decodes PPM edge timestamps into channel widths and drive commands.
// ----------------------------------------------------------------------------
// One edge is in work at a time. A sync gap, an edge past the eighth channel
// or a non-drive channel goes from filtering to output; a drive channel first
// passes mapping, scaling and the 8-step restoring divider that forms the
// percent magnitude. The next edge is taken the cycle after its predecessor's
// result is loaded into the output register, which holds it until taken.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_with_drive_mapping
  import ppmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ppmd_in_if.sink           in_i,
  ppmd_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  ppmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ppmd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .edge_time_i     (in_i.edge_time),
    .upper_limit_n_i (in_i.upper_limit_n),
    .lower_limit_n_i (in_i.lower_limit_n),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result)
  );

  assign out_o.updated         = result.updated;
  assign out_o.channel         = result.channel;
  assign out_o.pulse_width     = result.pulse_width;
  assign out_o.glitch_rejected = result.glitch_rejected;
  assign out_o.sync_seen       = result.sync_seen;
  assign out_o.frame_done      = result.frame_done;
  assign out_o.drive_valid     = result.drive_valid;
  assign out_o.direction       = result.direction;
  assign out_o.magnitude       = result.magnitude;

endmodule
